@@ rtl/core/calu_pkg.sv @@
// calu_pkg: operation codes shared by the alu with flags and its checker
// no dependencies

package calu_pkg;

    localparam int unsigned FUNC_W = 5;
    localparam int unsigned DATA_W = 16;
    localparam int unsigned BYTE_W = 8;

    typedef enum logic [FUNC_W-1:0] {
        F_ADD    = 5'd0,
        F_ADC    = 5'd1,
        F_SUB    = 5'd2,
        F_SBC    = 5'd3,
        F_AND    = 5'd4,
        F_OR     = 5'd5,
        F_XOR    = 5'd6,
        F_CP     = 5'd7,
        F_INC    = 5'd8,
        F_DEC    = 5'd9,
        F_SWAP   = 5'd10,
        F_RLC    = 5'd11,
        F_RRC    = 5'd12,
        F_RL     = 5'd13,
        F_RR     = 5'd14,
        F_SLA    = 5'd15,
        F_SRA    = 5'd16,
        F_SRL    = 5'd17,
        F_BIT    = 5'd18,
        F_DAA    = 5'd19,
        F_ADD16  = 5'd20,
        F_ADDSP  = 5'd21
    } t_func;

    // decimal adjust correction values
    localparam logic [BYTE_W-1:0] DAA_HI = 8'h60;
    localparam logic [BYTE_W-1:0] DAA_LO = 8'h06;

endpackage

@@ rtl/core/cpu_alu_with_flags.sv @@
// cpu_alu_with_flags: 8/16-bit cpu alu with z/n/h/c flags
// depends on calu_pkg
//
// usage
//   input channel: drive i_func, the operands and the incoming flags with
//   start high; the operation is taken at the rising edge where start is
//   high and busy is low. busy is always low: one operation per cycle.
//   result channel: o_valid pulses for one cycle with o_result and the new
//   flags; the result is transferred at the edge that ends that cycle.
// pipeline and throughput
//   an accepted operation passes one input register, one pass of
//   add/logic/flag logic and one result register before the result is
//   transferred. throughput is one operation per clock, set by that
//   single registered pass.
// reset
//   i_rst_n low at a rising edge clears both valid bits; operations in
//   flight are dropped and no result pulse follows them.
// stalls
//   the receiver cannot stall; results are never held or repeated.

module cpu_alu_with_flags (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [calu_pkg::FUNC_W-1:0]  i_func,
    input  logic [calu_pkg::DATA_W-1:0]  i_operand_a,
    input  logic [calu_pkg::DATA_W-1:0]  i_operand_b,
    input  logic                         i_zero_in,
    input  logic                         i_subtract_in,
    input  logic                         i_half_in,
    input  logic                         i_carry_in,
    output logic                         o_valid,
    output logic [calu_pkg::DATA_W-1:0]  o_result,
    output logic                         o_zero_out,
    output logic                         o_subtract_out,
    output logic                         o_half_out,
    output logic                         o_carry_out
);
    import calu_pkg::*;

    // input register
    logic              r_in_valid;
    logic [FUNC_W-1:0] r_func;
    logic [DATA_W-1:0] r_a16;
    logic [DATA_W-1:0] r_b16;
    logic              r_zi;
    logic              r_ni;
    logic              r_hi;
    logic              r_ci;

    // result register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_result;
    logic              r_z;
    logic              r_n;
    logic              r_h;
    logic              r_c;

    logic [DATA_W-1:0] n_result;
    logic              n_z;
    logic              n_n;
    logic              n_h;
    logic              n_c;

    logic              accept;

    // datapath intermediates
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic              k;
    logic [BYTE_W:0]   sum9;
    logic [4:0]        hsum5;
    logic [BYTE_W:0]   diff9;
    logic [4:0]        hdiff5;
    logic [BYTE_W-1:0] daa_k;
    logic              daa_c;
    logic [BYTE_W-1:0] r8;
    logic [DATA_W:0]   sum17;
    logic [12:0]       sum13;
    logic [DATA_W-1:0] sp_ext;
    logic [BYTE_W:0]   sp_lo9;
    logic [4:0]        sp_h5;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // capture operation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_func;
            r_a16  <= i_operand_a;
            r_b16  <= i_operand_b;
            r_zi   <= i_zero_in;
            r_ni   <= i_subtract_in;
            r_hi   <= i_half_in;
            r_ci   <= i_carry_in;
        end
    end

    // shared adders
    always_comb begin
        a      = r_a16[BYTE_W-1:0];
        b      = r_b16[BYTE_W-1:0];
        k      = (r_func == F_ADC || r_func == F_SBC) ? r_ci : 1'b0;
        sum9   = {1'b0, a} + {1'b0, b} + {{BYTE_W{1'b0}}, k};
        hsum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, k};
        diff9  = {1'b0, a} - {1'b0, b} - {{BYTE_W{1'b0}}, k};
        hdiff5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, k};
        sum17  = {1'b0, r_a16} + {1'b0, r_b16};
        sum13  = {1'b0, r_a16[11:0]} + {1'b0, r_b16[11:0]};
        sp_ext = {{BYTE_W{b[BYTE_W-1]}}, b};
        sp_lo9 = {1'b0, r_a16[BYTE_W-1:0]} + {1'b0, b};
        sp_h5  = {1'b0, r_a16[3:0]} + {1'b0, b[3:0]};
    end

    // decimal adjust correction
    always_comb begin
        daa_k = '0;
        daa_c = r_ci;
        if (!r_ni) begin
            if (r_ci || a > 8'h99) begin
                daa_k = daa_k | DAA_HI;
                daa_c = 1'b1;
            end
            if (r_hi || a[3:0] > 4'd9) begin
                daa_k = daa_k | DAA_LO;
            end
        end else begin
            if (r_ci) begin
                daa_k = daa_k | DAA_HI;
            end
            if (r_hi) begin
                daa_k = daa_k | DAA_LO;
            end
        end
    end

    // operation select and flags
    always_comb begin
        r8       = '0;
        n_result = r_a16;
        n_z      = r_zi;
        n_n      = r_ni;
        n_h      = r_hi;
        n_c      = r_ci;
        unique case (r_func)
            F_ADD, F_ADC: begin
                r8  = sum9[BYTE_W-1:0];
                n_n = 1'b0;
                n_h = hsum5[4];
                n_c = sum9[BYTE_W];
            end
            F_SUB, F_SBC, F_CP: begin
                r8  = diff9[BYTE_W-1:0];
                n_n = 1'b1;
                n_h = hdiff5[4];
                n_c = diff9[BYTE_W];
            end
            F_AND: begin
                r8  = a & b;
                n_n = 1'b0;
                n_h = 1'b1;
                n_c = 1'b0;
            end
            F_OR: begin
                r8  = a | b;
                n_n = 1'b0;
                n_h = 1'b0;
                n_c = 1'b0;
            end
            F_XOR: begin
                r8  = a ^ b;
                n_n = 1'b0;
                n_h = 1'b0;
                n_c = 1'b0;
            end
            F_INC: begin
                r8  = a + 8'd1;
                n_n = 1'b0;
                n_h = (a[3:0] == 4'hF);
            end
            F_DEC: begin
                r8  = a - 8'd1;
                n_n = 1'b1;
                n_h = (a[3:0] == 4'h0);
            end
            F_SWAP: begin
                r8  = {a[3:0], a[7:4]};
                n_n = 1'b0;
                n_h = 1'b0;
                n_c = 1'b0;
            end
            F_RLC: begin
                r8  = {a[6:0], a[7]};
                n_n = 1'b0;
                n_h = 1'b0;
                n_c = a[7];
            end
            F_RRC: begin
                r8  = {a[0], a[7:1]};
                n_n = 1'b0;
                n_h = 1'b0;
                n_c = a[0];
            end
            F_RL: begin
                r8  = {a[6:0], r_ci};
                n_n = 1'b0;
                n_h = 1'b0;
                n_c = a[7];
            end
            F_RR: begin
                r8  = {r_ci, a[7:1]};
                n_n = 1'b0;
                n_h = 1'b0;
                n_c = a[0];
            end
            F_SLA: begin
                r8  = {a[6:0], 1'b0};
                n_n = 1'b0;
                n_h = 1'b0;
                n_c = a[7];
            end
            F_SRA: begin
                r8  = {a[7], a[7:1]};
                n_n = 1'b0;
                n_h = 1'b0;
                n_c = a[0];
            end
            F_SRL: begin
                r8  = {1'b0, a[7:1]};
                n_n = 1'b0;
                n_h = 1'b0;
                n_c = a[0];
            end
            F_BIT: begin
                n_n = 1'b0;
                n_h = 1'b1;
            end
            F_DAA: begin
                r8  = r_ni ? (a - daa_k) : (a + daa_k);
                n_h = 1'b0;
                n_c = daa_c;
            end
            F_ADD16: begin
                n_result = sum17[DATA_W-1:0];
                n_n      = 1'b0;
                n_h      = sum13[12];
                n_c      = sum17[DATA_W];
            end
            F_ADDSP: begin
                n_result = r_a16 + sp_ext;
                n_z      = 1'b0;
                n_n      = 1'b0;
                n_h      = sp_h5[4];
                n_c      = sp_lo9[BYTE_W];
            end
            default: begin
                n_result = r_a16;
            end
        endcase

        // byte results: zero-extend, z from the byte
        if (r_func <= F_DAA && r_func != F_CP && r_func != F_BIT) begin
            n_result = {{BYTE_W{1'b0}}, r8};
        end
        if (r_func <= F_DAA && r_func != F_BIT) begin
            n_z = (r8 == '0);
        end
        if (r_func == F_BIT) begin
            n_z = !a[b[2:0]];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_result <= n_result;
            r_z      <= n_z;
            r_n      <= n_n;
            r_h      <= n_h;
            r_c      <= n_c;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result       = r_result;
    assign o_zero_out     = r_z;
    assign o_subtract_out = r_n;
    assign o_half_out     = r_h;
    assign o_carry_out    = r_c;

endmodule

@@ rtl/core/calu_checker.sv @@
// calu_checker: port-level assertions for cpu_alu_with_flags
// depends on calu_pkg; bound to the top level below

module calu_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [calu_pkg::FUNC_W-1:0]  i_func,
    input  logic [calu_pkg::DATA_W-1:0]  i_operand_a,
    input  logic                         o_valid,
    input  logic [calu_pkg::DATA_W-1:0]  o_result,
    input  logic                         o_zero_out,
    input  logic                         o_subtract_out
);
    import calu_pkg::*;

    // never refuses a transfer
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    // every result pulse comes from a transfer through the input and result registers
    a_valid_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("result without a transfer");

    // compare returns operand a and sets n
    a_cp_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == F_CP) |=> ##1
        (o_valid && o_result == $past(i_operand_a, 2) && o_subtract_out))
        else $error("compare result wrong");

    // byte and clears the upper byte, z follows the byte
    a_and_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == F_AND) |=> ##1
        (o_valid && o_result[15:8] == 8'h00 &&
         o_zero_out == (o_result[7:0] == 8'h00)))
        else $error("and result or zero flag wrong");

endmodule

bind cpu_alu_with_flags calu_checker u_calu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_func         (i_func),
    .i_operand_a    (i_operand_a),
    .o_valid        (o_valid),
    .o_result       (o_result),
    .o_zero_out     (o_zero_out),
    .o_subtract_out (o_subtract_out)
);

@@ tb/sv/tb_cpu_alu_with_flags.sv @@
// tb_cpu_alu_with_flags: self-checking bench for the alu with z/n/h/c flags
// depends on calu_pkg and cpu_alu_with_flags; directed corner cases, then bursts of
// random operations, each result checked against a flag-exact prediction
`timescale 1ns / 100ps

typedef struct packed {
    logic [calu_pkg::FUNC_W-1:0] func;
    logic [calu_pkg::DATA_W-1:0] a;
    logic [calu_pkg::DATA_W-1:0] b;
    logic                        z;
    logic                        n;
    logic                        h;
    logic                        c;
} t_alu_op;

typedef struct packed {
    logic [calu_pkg::DATA_W-1:0] value;
    logic                        z;
    logic                        n;
    logic                        h;
    logic                        c;
} t_alu_res;

// tracks the flag results still owed by the alu, in transfer order
class alu_flag_tracker;
    t_alu_res owed_results[$];
    int       errors;

    function new();
        errors = 0;
    endfunction

    // sm83 style operation and flag behavior
    function t_alu_res alu_flags_calc(t_alu_op op);
        t_alu_res   r;
        logic [7:0] a8;
        logic [7:0] b8;
        logic [7:0] v8;
        logic [7:0] adj;
        logic       k;
        logic       cy;
        int         sum;
        logic [16:0] wide;

        a8 = op.a[7:0];
        b8 = op.b[7:0];
        k  = 1'b0;
        r  = '0;
        case (op.func)
            calu_pkg::F_ADD, calu_pkg::F_ADC: begin
                k       = (op.func == calu_pkg::F_ADC) ? op.c : 1'b0;
                sum     = int'(a8) + int'(b8) + int'(k);
                v8      = sum[7:0];
                r.value = {8'h00, v8};
                r.z     = (v8 == 8'h00);
                r.h     = (int'(a8[3:0]) + int'(b8[3:0]) + int'(k)) > 15;
                r.c     = sum > 255;
            end
            calu_pkg::F_SUB, calu_pkg::F_SBC, calu_pkg::F_CP: begin
                k       = (op.func == calu_pkg::F_SBC) ? op.c : 1'b0;
                v8      = a8 - b8 - {7'd0, k};
                r.value = (op.func == calu_pkg::F_CP) ? op.a : {8'h00, v8};
                r.z     = (v8 == 8'h00);
                r.n     = 1'b1;
                r.h     = int'(a8[3:0]) < (int'(b8[3:0]) + int'(k));
                r.c     = int'(a8) < (int'(b8) + int'(k));
            end
            calu_pkg::F_AND: begin
                v8      = a8 & b8;
                r.value = {8'h00, v8};
                r.z     = (v8 == 8'h00);
                r.h     = 1'b1;
            end
            calu_pkg::F_OR, calu_pkg::F_XOR: begin
                v8      = (op.func == calu_pkg::F_OR) ? (a8 | b8) : (a8 ^ b8);
                r.value = {8'h00, v8};
                r.z     = (v8 == 8'h00);
            end
            calu_pkg::F_INC, calu_pkg::F_DEC: begin
                // carry is left alone by inc and dec
                if (op.func == calu_pkg::F_INC) begin
                    v8  = a8 + 8'd1;
                    r.h = (a8[3:0] == 4'hF);
                end else begin
                    v8  = a8 - 8'd1;
                    r.n = 1'b1;
                    r.h = (a8[3:0] == 4'h0);
                end
                r.value = {8'h00, v8};
                r.z     = (v8 == 8'h00);
                r.c     = op.c;
            end
            calu_pkg::F_SWAP, calu_pkg::F_RLC, calu_pkg::F_RRC, calu_pkg::F_RL,
            calu_pkg::F_RR, calu_pkg::F_SLA, calu_pkg::F_SRA, calu_pkg::F_SRL: begin
                // prefixed rotates and shifts: z from the byte, n and h clear
                cy = 1'b0;
                case (op.func)
                    calu_pkg::F_SWAP: v8 = {a8[3:0], a8[7:4]};
                    calu_pkg::F_RLC: begin v8 = {a8[6:0], a8[7]}; cy = a8[7]; end
                    calu_pkg::F_RRC: begin v8 = {a8[0], a8[7:1]}; cy = a8[0]; end
                    calu_pkg::F_RL:  begin v8 = {a8[6:0], op.c};  cy = a8[7]; end
                    calu_pkg::F_RR:  begin v8 = {op.c, a8[7:1]};  cy = a8[0]; end
                    calu_pkg::F_SLA: begin v8 = {a8[6:0], 1'b0};  cy = a8[7]; end
                    calu_pkg::F_SRA: begin v8 = {a8[7], a8[7:1]}; cy = a8[0]; end
                    default:         begin v8 = {1'b0, a8[7:1]};  cy = a8[0]; end
                endcase
                r.value = {8'h00, v8};
                r.z     = (v8 == 8'h00);
                r.c     = cy;
            end
            calu_pkg::F_BIT: begin
                r.value = op.a;
                r.z     = ~a8[b8[2:0]];
                r.h     = 1'b1;
                r.c     = op.c;
            end
            calu_pkg::F_DAA: begin
                adj = 8'h00;
                cy  = op.c;
                if (!op.n) begin
                    if (op.c || a8 > 8'h99) begin
                        adj = adj | calu_pkg::DAA_HI;
                        cy  = 1'b1;
                    end
                    if (op.h || a8[3:0] > 4'd9)
                        adj = adj | calu_pkg::DAA_LO;
                    v8 = a8 + adj;
                end else begin
                    if (op.c)
                        adj = adj | calu_pkg::DAA_HI;
                    if (op.h)
                        adj = adj | calu_pkg::DAA_LO;
                    v8 = a8 - adj;
                end
                r.value = {8'h00, v8};
                r.z     = (v8 == 8'h00);
                r.n     = op.n;
                r.c     = cy;
            end
            calu_pkg::F_ADD16: begin
                // z kept, half-carry out of bit 11
                wide    = {1'b0, op.a} + {1'b0, op.b};
                r.value = wide[15:0];
                r.z     = op.z;
                r.h     = (int'(op.a[11:0]) + int'(op.b[11:0])) > 12'hFFF;
                r.c     = wide[16];
            end
            calu_pkg::F_ADDSP: begin
                // signed offset, flags from the unsigned low byte add
                r.value = op.a + {{8{b8[7]}}, b8};
                r.h     = (int'(op.a[3:0]) + int'(b8[3:0])) > 15;
                r.c     = (int'(op.a[7:0]) + int'(b8)) > 255;
            end
            default: begin
                // unused codes pass operand and flags through
                r.value = op.a;
                r.z     = op.z;
                r.n     = op.n;
                r.h     = op.h;
                r.c     = op.c;
            end
        endcase
        return r;
    endfunction

    function void note_op(t_alu_op op);
        owed_results.push_back(alu_flags_calc(op));
    endfunction

    function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endfunction

    function void check_result(t_alu_res got);
        t_alu_res want;
        if (owed_results.size() == 0) begin
            $error("result transfer with nothing outstanding: result %h", got.value);
            errors++;
            return;
        end
        want = owed_results.pop_front();
        cmp_field("result", want.value, got.value);
        cmp_field("zero_out", 16'(want.z), 16'(got.z));
        cmp_field("subtract_out", 16'(want.n), 16'(got.n));
        cmp_field("half_out", 16'(want.h), 16'(got.h));
        cmp_field("carry_out", 16'(want.c), 16'(got.c));
    endfunction

    function int owed();
        return owed_results.size();
    endfunction
endclass

module tb_cpu_alu_with_flags;
    import calu_pkg::*;

    localparam int RAND_OPS = 1450;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [FUNC_W-1:0]   i_func;
    logic [DATA_W-1:0]   i_operand_a;
    logic [DATA_W-1:0]   i_operand_b;
    logic                i_zero_in;
    logic                i_subtract_in;
    logic                i_half_in;
    logic                i_carry_in;
    logic                o_valid;
    logic [DATA_W-1:0]   o_result;
    logic                o_zero_out;
    logic                o_subtract_out;
    logic                o_half_out;
    logic                o_carry_out;

    alu_flag_tracker tracker = new();

    cpu_alu_with_flags dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_zero_in      (i_zero_in),
        .i_subtract_in  (i_subtract_in),
        .i_half_in      (i_half_in),
        .i_carry_in     (i_carry_in),
        .o_valid        (o_valid),
        .o_result       (o_result),
        .o_zero_out     (o_zero_out),
        .o_subtract_out (o_subtract_out),
        .o_half_out     (o_half_out),
        .o_carry_out    (o_carry_out)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // note accepted operations, then check any result transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                tracker.note_op({i_func, i_operand_a, i_operand_b,
                                 i_zero_in, i_subtract_in, i_half_in, i_carry_in});
            if (o_valid)
                tracker.check_result({o_result, o_zero_out, o_subtract_out,
                                      o_half_out, o_carry_out});
        end
    end

    function automatic t_alu_op mk_op(t_func f, logic [15:0] a, logic [15:0] b,
                                      logic [3:0] flags);
        return {f, a, b, flags};
    endfunction

    // operand with a bias toward the carry and borrow corners
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return {8'h00, 8'(($urandom_range(0, 15) << 4) | 4'hF)};
            3:       return {8'($urandom), 8'h00};
            4:       return 16'(1 << $urandom_range(0, 15));
            5:       return {8'h00, 8'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_alu_op rand_op();
        t_alu_op op;
        if ($urandom_range(0, 9) == 0)
            op.func = 5'($urandom_range(22, 31));
        else
            op.func = 5'($urandom_range(0, 21));
        op.a = pick_word();
        op.b = pick_word();
        {op.z, op.n, op.h, op.c} = 4'($urandom);
        return op;
    endfunction

    // one transfer on the input side; called and returns at a falling edge
    task automatic send_op(t_alu_op op);
        start         <= 1'b1;
        i_func        <= op.func;
        i_operand_a   <= op.a;
        i_operand_b   <= op.b;
        i_zero_in     <= op.z;
        i_subtract_in <= op.n;
        i_half_in     <= op.h;
        i_carry_in    <= op.c;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // idle cycles with junk on the operand lines
    task automatic idle_gap(int cycles);
        t_alu_op junk;
        start <= 1'b0;
        repeat (cycles) begin
            junk = rand_op();
            {i_func, i_operand_a, i_operand_b} <= {junk.func, junk.a, junk.b};
            {i_zero_in, i_subtract_in, i_half_in, i_carry_in} <=
                {junk.z, junk.n, junk.h, junk.c};
            @(negedge i_clk);
        end
    endtask

    t_alu_op corner_ops[$];

    initial begin
        int sent;
        int burst;

        start         = 1'b0;
        i_rst_n       = 1'b0;
        i_func        = '0;
        i_operand_a   = '0;
        i_operand_b   = '0;
        i_zero_in     = 1'b0;
        i_subtract_in = 1'b0;
        i_half_in     = 1'b0;
        i_carry_in    = 1'b0;

        // reset held low, then released at a falling edge
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corners: carries, borrows, flag keeping, decimal adjust, unused codes
        corner_ops.push_back(mk_op(F_ADD,   16'h00FF, 16'h0001, 4'b0000));
        corner_ops.push_back(mk_op(F_ADC,   16'h000F, 16'h0000, 4'b0001));
        corner_ops.push_back(mk_op(F_SUB,   16'h0000, 16'h0001, 4'b0000));
        corner_ops.push_back(mk_op(F_SBC,   16'h0010, 16'h000F, 4'b0001));
        corner_ops.push_back(mk_op(F_AND,   16'h0000, 16'hFFFF, 4'b1111));
        corner_ops.push_back(mk_op(F_OR,    16'hFFFF, 16'h0000, 4'b0000));
        corner_ops.push_back(mk_op(F_XOR,   16'h00AA, 16'h0055, 4'b1111));
        corner_ops.push_back(mk_op(F_CP,    16'hFFFF, 16'h00FF, 4'b0000));
        corner_ops.push_back(mk_op(F_INC,   16'h00FF, 16'h0000, 4'b0001));
        corner_ops.push_back(mk_op(F_DEC,   16'h0010, 16'h0000, 4'b0000));
        corner_ops.push_back(mk_op(F_SWAP,  16'h00F0, 16'h0000, 4'b0000));
        corner_ops.push_back(mk_op(F_RLC,   16'h0080, 16'h0000, 4'b0000));
        corner_ops.push_back(mk_op(F_RRC,   16'h0001, 16'h0000, 4'b0000));
        corner_ops.push_back(mk_op(F_RL,    16'h0080, 16'h0000, 4'b0001));
        corner_ops.push_back(mk_op(F_RR,    16'h0001, 16'h0000, 4'b0001));
        corner_ops.push_back(mk_op(F_SLA,   16'h0080, 16'h0000, 4'b0000));
        corner_ops.push_back(mk_op(F_SRA,   16'h0081, 16'h0000, 4'b0000));
        corner_ops.push_back(mk_op(F_SRL,   16'h0001, 16'h0000, 4'b0000));
        corner_ops.push_back(mk_op(F_BIT,   16'h1280, 16'h0007, 4'b0000));
        corner_ops.push_back(mk_op(F_BIT,   16'h0000, 16'hFFF8, 4'b0001));
        corner_ops.push_back(mk_op(F_DAA,   16'h009A, 16'h0000, 4'b0000));
        corner_ops.push_back(mk_op(F_DAA,   16'h0000, 16'h0000, 4'b0111));
        corner_ops.push_back(mk_op(F_ADD16, 16'hFFFF, 16'h0001, 4'b1000));
        corner_ops.push_back(mk_op(F_ADDSP, 16'hFFFF, 16'h0080, 4'b1111));
        corner_ops.push_back({5'd31, 16'h1234, 16'hFFFF, 4'b1111});
        corner_ops.push_back({5'd22, 16'hFFFF, 16'h0000, 4'b0000});
        foreach (corner_ops[i])
            send_op(corner_ops[i]);

        // random bursts with random gaps, some back to back
        sent = 0;
        while (sent < RAND_OPS) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                send_op(rand_op());
                sent++;
            end
            if ($urandom_range(0, 9) >= 3)
                idle_gap($urandom_range(1, 8));
        end
        idle_gap(1);

        // drain, then allow for the pipeline depth
        while (tracker.owed() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        if (tracker.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
